### rtl/vdp_pkg.sv
package vdp_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int ADDR_W      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;

    localparam logic [1:0]  MODE_WRITE = 2'd0;
    localparam logic [1:0]  MODE_READ  = 2'd1;
    localparam logic [1:0]  MODE_PIXEL = 2'd2;

    localparam logic [15:0] PORT_READ_INDEX  = 16'h03c7;
    localparam logic [15:0] PORT_WRITE_INDEX = 16'h03c8;
    localparam logic [15:0] PORT_DATA        = 16'h03c9;

    localparam logic [1:0]  PHASE_RED   = 2'd0;
    localparam logic [1:0]  PHASE_GREEN = 2'd1;
    localparam logic [1:0]  PHASE_BLUE  = 2'd2;

    localparam logic [8:0]  ENTRIES_9   = 9'(PAL_ENTRIES);
    localparam logic [8:0]  LAST_9      = 9'(PAL_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MERGE,
        ST_DONE
    } vdp_state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [23:0]       wr_data;
    } vdp_ram_req_t;

    localparam logic [7:0] DEFAULT_RGB [768] = '{
        8'd0,8'd0,8'd0, 8'd0,8'd0,8'd170, 8'd0,8'd170,8'd0, 8'd0,8'd170,8'd170,
        8'd170,8'd0,8'd0, 8'd170,8'd0,8'd170, 8'd170,8'd85,8'd0, 8'd170,8'd170,8'd170,
        8'd85,8'd85,8'd85, 8'd85,8'd85,8'd255, 8'd85,8'd255,8'd85, 8'd85,8'd255,8'd255,
        8'd255,8'd85,8'd85, 8'd255,8'd85,8'd255, 8'd255,8'd255,8'd85, 8'd255,8'd255,8'd255,
        8'd0,8'd0,8'd0, 8'd20,8'd20,8'd20, 8'd32,8'd32,8'd32, 8'd44,8'd44,8'd44,
        8'd56,8'd56,8'd56, 8'd69,8'd69,8'd69, 8'd81,8'd81,8'd81, 8'd97,8'd97,8'd97,
        8'd113,8'd113,8'd113, 8'd130,8'd130,8'd130, 8'd146,8'd146,8'd146,
        8'd162,8'd162,8'd162,
        8'd182,8'd182,8'd182, 8'd203,8'd203,8'd203, 8'd227,8'd227,8'd227,
        8'd255,8'd255,8'd255,
        8'd0,8'd0,8'd255, 8'd65,8'd0,8'd255, 8'd125,8'd0,8'd255, 8'd190,8'd0,8'd255,
        8'd255,8'd0,8'd255, 8'd255,8'd0,8'd190, 8'd255,8'd0,8'd125, 8'd255,8'd0,8'd65,
        8'd255,8'd0,8'd0, 8'd255,8'd65,8'd0, 8'd255,8'd125,8'd0, 8'd255,8'd190,8'd0,
        8'd255,8'd255,8'd0, 8'd190,8'd255,8'd0, 8'd125,8'd255,8'd0, 8'd65,8'd255,8'd0,
        8'd0,8'd255,8'd0, 8'd0,8'd255,8'd65, 8'd0,8'd255,8'd125, 8'd0,8'd255,8'd190,
        8'd0,8'd255,8'd255, 8'd0,8'd190,8'd255, 8'd0,8'd125,8'd255, 8'd0,8'd65,8'd255,
        8'd125,8'd125,8'd255, 8'd158,8'd125,8'd255, 8'd190,8'd125,8'd255,
        8'd223,8'd125,8'd255,
        8'd255,8'd125,8'd255, 8'd255,8'd125,8'd223, 8'd255,8'd125,8'd190,
        8'd255,8'd125,8'd158,
        8'd255,8'd125,8'd125, 8'd255,8'd158,8'd125, 8'd255,8'd190,8'd125,
        8'd255,8'd223,8'd125,
        8'd255,8'd255,8'd125, 8'd223,8'd255,8'd125, 8'd190,8'd255,8'd125,
        8'd158,8'd255,8'd125,
        8'd125,8'd255,8'd125, 8'd125,8'd255,8'd158, 8'd125,8'd255,8'd190,
        8'd125,8'd255,8'd223,
        8'd125,8'd255,8'd255, 8'd125,8'd223,8'd255, 8'd125,8'd190,8'd255,
        8'd125,8'd158,8'd255,
        8'd182,8'd182,8'd255, 8'd199,8'd182,8'd255, 8'd219,8'd182,8'd255,
        8'd235,8'd182,8'd255,
        8'd255,8'd182,8'd255, 8'd255,8'd182,8'd235, 8'd255,8'd182,8'd219,
        8'd255,8'd182,8'd199,
        8'd255,8'd182,8'd182, 8'd255,8'd199,8'd182, 8'd255,8'd219,8'd182,
        8'd255,8'd235,8'd182,
        8'd255,8'd255,8'd182, 8'd235,8'd255,8'd182, 8'd219,8'd255,8'd182,
        8'd199,8'd255,8'd182,
        8'd182,8'd255,8'd182, 8'd182,8'd255,8'd199, 8'd182,8'd255,8'd219,
        8'd182,8'd255,8'd235,
        8'd182,8'd255,8'd255, 8'd182,8'd235,8'd255, 8'd182,8'd219,8'd255,
        8'd182,8'd199,8'd255,
        8'd0,8'd0,8'd113, 8'd28,8'd0,8'd113, 8'd56,8'd0,8'd113, 8'd85,8'd0,8'd113,
        8'd113,8'd0,8'd113, 8'd113,8'd0,8'd85, 8'd113,8'd0,8'd56, 8'd113,8'd0,8'd28,
        8'd113,8'd0,8'd0, 8'd113,8'd28,8'd0, 8'd113,8'd56,8'd0, 8'd113,8'd85,8'd0,
        8'd113,8'd113,8'd0, 8'd85,8'd113,8'd0, 8'd56,8'd113,8'd0, 8'd28,8'd113,8'd0,
        8'd0,8'd113,8'd0, 8'd0,8'd113,8'd28, 8'd0,8'd113,8'd56, 8'd0,8'd113,8'd85,
        8'd0,8'd113,8'd113, 8'd0,8'd85,8'd113, 8'd0,8'd56,8'd113, 8'd0,8'd28,8'd113,
        8'd56,8'd56,8'd113, 8'd69,8'd56,8'd113, 8'd85,8'd56,8'd113, 8'd97,8'd56,8'd113,
        8'd113,8'd56,8'd113, 8'd113,8'd56,8'd97, 8'd113,8'd56,8'd85, 8'd113,8'd56,8'd69,
        8'd113,8'd56,8'd56, 8'd113,8'd69,8'd56, 8'd113,8'd85,8'd56, 8'd113,8'd97,8'd56,
        8'd113,8'd113,8'd56, 8'd97,8'd113,8'd56, 8'd85,8'd113,8'd56, 8'd69,8'd113,8'd56,
        8'd56,8'd113,8'd56, 8'd56,8'd113,8'd69, 8'd56,8'd113,8'd85, 8'd56,8'd113,8'd97,
        8'd56,8'd113,8'd113, 8'd56,8'd97,8'd113, 8'd56,8'd85,8'd113, 8'd56,8'd69,8'd113,
        8'd81,8'd81,8'd113, 8'd89,8'd81,8'd113, 8'd97,8'd81,8'd113, 8'd105,8'd81,8'd113,
        8'd113,8'd81,8'd113, 8'd113,8'd81,8'd105, 8'd113,8'd81,8'd97, 8'd113,8'd81,8'd89,
        8'd113,8'd81,8'd81, 8'd113,8'd89,8'd81, 8'd113,8'd97,8'd81, 8'd113,8'd105,8'd81,
        8'd113,8'd113,8'd81, 8'd105,8'd113,8'd81, 8'd97,8'd113,8'd81, 8'd89,8'd113,8'd81,
        8'd81,8'd113,8'd81, 8'd81,8'd113,8'd89, 8'd81,8'd113,8'd97, 8'd81,8'd113,8'd105,
        8'd81,8'd113,8'd113, 8'd81,8'd105,8'd113, 8'd81,8'd97,8'd113, 8'd81,8'd89,8'd113,
        8'd0,8'd0,8'd65, 8'd16,8'd0,8'd65, 8'd32,8'd0,8'd65, 8'd48,8'd0,8'd65,
        8'd65,8'd0,8'd65, 8'd65,8'd0,8'd48, 8'd65,8'd0,8'd32, 8'd65,8'd0,8'd16,
        8'd65,8'd0,8'd0, 8'd65,8'd16,8'd0, 8'd65,8'd32,8'd0, 8'd65,8'd48,8'd0,
        8'd65,8'd65,8'd0, 8'd48,8'd65,8'd0, 8'd32,8'd65,8'd0, 8'd16,8'd65,8'd0,
        8'd0,8'd65,8'd0, 8'd0,8'd65,8'd16, 8'd0,8'd65,8'd32, 8'd0,8'd65,8'd48,
        8'd0,8'd65,8'd65, 8'd0,8'd48,8'd65, 8'd0,8'd32,8'd65, 8'd0,8'd16,8'd65,
        8'd32,8'd32,8'd65, 8'd40,8'd32,8'd65, 8'd48,8'd32,8'd65, 8'd56,8'd32,8'd65,
        8'd65,8'd32,8'd65, 8'd65,8'd32,8'd56, 8'd65,8'd32,8'd48, 8'd65,8'd32,8'd40,
        8'd65,8'd32,8'd32, 8'd65,8'd40,8'd32, 8'd65,8'd48,8'd32, 8'd65,8'd56,8'd32,
        8'd65,8'd65,8'd32, 8'd56,8'd65,8'd32, 8'd48,8'd65,8'd32, 8'd40,8'd65,8'd32,
        8'd32,8'd65,8'd32, 8'd32,8'd65,8'd40, 8'd32,8'd65,8'd48, 8'd32,8'd65,8'd56,
        8'd32,8'd65,8'd65, 8'd32,8'd56,8'd65, 8'd32,8'd48,8'd65, 8'd32,8'd40,8'd65,
        8'd44,8'd44,8'd65, 8'd48,8'd44,8'd65, 8'd52,8'd44,8'd65, 8'd60,8'd44,8'd65,
        8'd65,8'd44,8'd65, 8'd65,8'd44,8'd60, 8'd65,8'd44,8'd52, 8'd65,8'd44,8'd48,
        8'd65,8'd44,8'd44, 8'd65,8'd48,8'd44, 8'd65,8'd52,8'd44, 8'd65,8'd60,8'd44,
        8'd65,8'd65,8'd44, 8'd60,8'd65,8'd44, 8'd52,8'd65,8'd44, 8'd48,8'd65,8'd44,
        8'd44,8'd65,8'd44, 8'd44,8'd65,8'd48, 8'd44,8'd65,8'd52, 8'd44,8'd65,8'd60,
        8'd44,8'd65,8'd65, 8'd44,8'd60,8'd65, 8'd44,8'd52,8'd65, 8'd44,8'd48,8'd65,
        8'd0,8'd0,8'd0, 8'd0,8'd0,8'd0, 8'd0,8'd0,8'd0, 8'd0,8'd0,8'd0,
        8'd0,8'd0,8'd0, 8'd0,8'd0,8'd0, 8'd0,8'd0,8'd0, 8'd0,8'd0,8'd0
    };

endpackage

### rtl/vdp_palette_ram.sv
module vdp_palette_ram (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vdp_pkg::vdp_ram_req_t req,
    output logic [23:0]           rd_data
);

    logic [23:0] mem [vdp_pkg::PAL_ENTRIES];
    logic        valid_reg [vdp_pkg::PAL_ENTRIES];
    logic [23:0] mem_q_reg;
    logic [23:0] def_q_reg;
    logic        valid_q_reg;
    logic [9:0]  base;

    assign base = 10'({2'b00, 8'(req.rd_addr)} * 10'd3);

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg <= mem[req.rd_addr];
            def_q_reg <= {vdp_pkg::DEFAULT_RGB[base],
                          vdp_pkg::DEFAULT_RGB[base + 10'd1],
                          vdp_pkg::DEFAULT_RGB[base + 10'd2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vdp_pkg::PAL_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            valid_q_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                valid_q_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = valid_q_reg ? mem_q_reg : def_q_reg;

endmodule

### rtl/vga_dac_palette_ports.sv
// channel | direction | tdata fields (lowest bit up)
// s_axis  | in        | mode[1:0] port_address[17:2] write_data[25:18] pixel_index[33:26]
// m_axis  | out       | read_data[5:0] pixel_rgb[29:6] unknown_port[30]
// Each word steps through capture, palette RAM read, merge and write back, and result, in that order.
// The palette RAM read is registered; the merge step then writes the modified row back.
// Reset clears the per-entry valid bits at once; unwritten entries read the default palette.
// A waiting result blocks the next word until m_axis_tready takes it.
module vga_dac_palette_ports (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // mode, port_address, write_data, pixel_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // read_data, pixel_rgb, unknown_port
);

    vdp_pkg::vdp_state_t state_reg, state_next;
    vdp_pkg::vdp_ram_req_t req;

    logic [1:0]  mode_reg;
    logic [15:0] port_reg;
    logic [7:0]  wdata_reg;
    logic [7:0]  pix_reg;

    logic [7:0]  write_index_reg, write_index_next;
    logic [1:0]  write_phase_reg, write_phase_next;
    logic [7:0]  read_index_reg, read_index_next;
    logic [1:0]  read_phase_reg, read_phase_next;

    logic [5:0]  rd_out_reg, rd_out_next;
    logic [23:0] rgb_out_reg, rgb_out_next;
    logic        unk_out_reg, unk_out_next;

    logic [23:0] row;
    logic [7:0]  sel_index;
    logic        in_range;
    logic [7:0]  comp;
    logic [7:0]  value;
    logic [23:0] merged;
    logic        wr_hit;

    function automatic logic [7:0] next_index(input logic [7:0] idx);
        logic [7:0] r;
        if ({1'b0, idx} >= vdp_pkg::LAST_9)
        begin
            r = 8'd0;
        end
        else
        begin
            r = idx + 8'd1;
        end
        return r;
    endfunction

    always_comb
    begin
        unique case (mode_reg)
            vdp_pkg::MODE_PIXEL: sel_index = pix_reg;
            vdp_pkg::MODE_READ:  sel_index = read_index_reg;
            default:             sel_index = write_index_reg;
        endcase
    end

    assign in_range = ({1'b0, sel_index} < vdp_pkg::ENTRIES_9);
    assign value    = {wdata_reg[5:0], 2'b00};

    always_comb
    begin
        unique case (read_phase_reg)
            vdp_pkg::PHASE_RED:   comp = row[23:16];
            vdp_pkg::PHASE_GREEN: comp = row[15:8];
            default:              comp = row[7:0];
        endcase
    end

    always_comb
    begin
        merged = row;
        unique case (write_phase_reg)
            vdp_pkg::PHASE_RED:   merged[23:16] = value;
            vdp_pkg::PHASE_GREEN: merged[15:8]  = value;
            default:              merged[7:0]   = value;
        endcase
    end

    assign wr_hit = (state_reg == vdp_pkg::ST_MERGE) && (mode_reg == vdp_pkg::MODE_WRITE)
                    && (port_reg == vdp_pkg::PORT_DATA) && in_range;

    always_comb
    begin
        req.rd_en   = (state_reg == vdp_pkg::ST_ISSUE);
        req.rd_addr = sel_index[vdp_pkg::ADDR_W-1:0];
        req.wr_en   = wr_hit;
        req.wr_addr = sel_index[vdp_pkg::ADDR_W-1:0];
        req.wr_data = merged;
    end

    vdp_palette_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (row)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vdp_pkg::ST_IDLE:  if (s_axis_tvalid) state_next = vdp_pkg::ST_ISSUE;
            vdp_pkg::ST_ISSUE: state_next = vdp_pkg::ST_MERGE;
            vdp_pkg::ST_MERGE: state_next = vdp_pkg::ST_DONE;
            vdp_pkg::ST_DONE:  if (m_axis_tready) state_next = vdp_pkg::ST_IDLE;
            default:           state_next = vdp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        write_index_next = write_index_reg;
        write_phase_next = write_phase_reg;
        read_index_next  = read_index_reg;
        read_phase_next  = read_phase_reg;
        rd_out_next      = 6'd0;
        rgb_out_next     = 24'd0;
        unk_out_next     = 1'b0;
        unique case (mode_reg)
            vdp_pkg::MODE_WRITE:
            begin
                priority if (port_reg == vdp_pkg::PORT_READ_INDEX)
                begin
                    read_index_next = wdata_reg;
                    read_phase_next = vdp_pkg::PHASE_RED;
                end
                else if (port_reg == vdp_pkg::PORT_WRITE_INDEX)
                begin
                    write_index_next = wdata_reg;
                    write_phase_next = vdp_pkg::PHASE_RED;
                end
                else if (port_reg == vdp_pkg::PORT_DATA)
                begin
                    if (write_phase_reg == vdp_pkg::PHASE_BLUE)
                    begin
                        write_phase_next = vdp_pkg::PHASE_RED;
                        write_index_next = next_index(write_index_reg);
                    end
                    else
                    begin
                        write_phase_next = write_phase_reg + 2'd1;
                    end
                end
                else
                begin
                    unk_out_next = 1'b1;
                end
            end
            vdp_pkg::MODE_READ:
            begin
                if (port_reg == vdp_pkg::PORT_DATA)
                begin
                    rd_out_next = in_range ? comp[7:2] : 6'd0;
                    if (read_phase_reg == vdp_pkg::PHASE_BLUE)
                    begin
                        read_phase_next = vdp_pkg::PHASE_RED;
                        read_index_next = next_index(read_index_reg);
                    end
                    else
                    begin
                        read_phase_next = read_phase_reg + 2'd1;
                    end
                end
                else
                begin
                    unk_out_next = 1'b1;
                end
            end
            vdp_pkg::MODE_PIXEL:
            begin
                rgb_out_next = in_range ? row : 24'd0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= vdp_pkg::ST_IDLE;
            write_index_reg <= 8'd0;
            write_phase_reg <= vdp_pkg::PHASE_RED;
            read_index_reg  <= 8'd0;
            read_phase_reg  <= vdp_pkg::PHASE_RED;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == vdp_pkg::ST_MERGE)
            begin
                write_index_reg <= write_index_next;
                write_phase_reg <= write_phase_next;
                read_index_reg  <= read_index_next;
                read_phase_reg  <= read_phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            mode_reg  <= s_axis_tdata[1:0];
            port_reg  <= s_axis_tdata[17:2];
            wdata_reg <= s_axis_tdata[25:18];
            pix_reg   <= s_axis_tdata[33:26];
        end
        if (state_reg == vdp_pkg::ST_MERGE)
        begin
            rd_out_reg  <= rd_out_next;
            rgb_out_reg <= rgb_out_next;
            unk_out_reg <= unk_out_next;
        end
    end

    always_comb
    begin
        s_axis_tready = (state_reg == vdp_pkg::ST_IDLE);
        m_axis_tvalid = (state_reg == vdp_pkg::ST_DONE);
        m_axis_tdata  = {1'b0, unk_out_reg, rgb_out_reg, rd_out_reg};
    end

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input accepted while a result is pending");
    a_wr_merge: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> (state_reg == vdp_pkg::ST_MERGE))
        else $error("palette write outside merge");
    a_wphase: assert property (@(posedge clk) disable iff (!rst_n)
        write_phase_reg != 2'd3)
        else $error("write phase out of range");
    a_rphase: assert property (@(posedge clk) disable iff (!rst_n)
        read_phase_reg != 2'd3)
        else $error("read phase out of range");
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && unk_out_reg |-> (rd_out_reg == 6'd0) && (rgb_out_reg == 24'd0))
        else $error("unknown port result carries data");

endmodule
